FILE: rtl/lfo_pkg.sv
// Shared types and constants of the low-frequency oscillator.
`default_nettype none
package lfo_pkg;

	// Waveform select codes.
	typedef enum logic [2:0] {
		WAVE_TRIANGLE  = 3'd0,
		WAVE_SINE      = 3'd1,
		WAVE_RAMP_UP   = 3'd2,
		WAVE_RAMP_DOWN = 3'd3,
		WAVE_SQUARE    = 3'd4,
		WAVE_PULSE     = 3'd5,
		WAVE_RANDOM    = 3'd6,
		WAVE_RAND_RAMP = 3'd7
	} wave_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_WAVEFORM   = 2'd0,
		CFG_PHASE_INC  = 2'd1,
		CFG_PULSE_WIDTH = 2'd2,
		CFG_RANDOM_SEED = 2'd3
	} cfg_idx_t;

	// Input actions.
	typedef enum logic {
		ACT_TICK = 1'b0,
		ACT_LOAD = 1'b1
	} action_t;

	typedef logic signed [15:0] sample_t;

	localparam logic [31:0] LFSR_MASK      = 32'h8020_0003;
	localparam logic [15:0] PULSE_WIDTH_RST = 16'h8000;
	localparam logic [31:0] SEED_RST       = 32'h0000_0001;
	localparam sample_t     SAMPLE_MAX     = 16'sh7FFF;
	localparam sample_t     SAMPLE_MIN     = -16'sh7FFF;

	// Saturate a wide intermediate to the symmetric Q1.15 range.
	function automatic sample_t sat16(input logic signed [18:0] v);
		sample_t r;
		if (v > 19'sd32767) begin
			r = SAMPLE_MAX;
		end else if (v < -19'sd32767) begin
			r = SAMPLE_MIN;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/lfo_in_if.sv
// Input channel of the oscillator: action and phase value.
`default_nettype none
interface lfo_in_if;
	logic            valid;
	logic            ready;
	lfo_pkg::action_t action;
	logic [31:0]     phase_value;

	modport source (output valid, output action, output phase_value, input ready);
	modport sink   (input valid, input action, input phase_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/lfo_out_if.sv
// Result channel of the oscillator: sample and phase.
`default_nettype none
interface lfo_out_if;
	logic             valid;
	logic             ready;
	lfo_pkg::sample_t sample;
	logic [31:0]      phase;

	modport source (output valid, output sample, output phase, input ready);
	modport sink   (input valid, input sample, input phase, output ready);
endinterface
`default_nettype wire

FILE: rtl/lfo_cfg_if.sv
// Configuration write channel of the oscillator.
`default_nettype none
interface lfo_cfg_if;
	logic              valid;
	logic              ready;
	lfo_pkg::cfg_idx_t index;
	logic [31:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/lfo_waveform_generator.sv
// Top level of the phase-accumulator low-frequency oscillator.
//
//  Channel | Direction | Payload                      | Transfer when
//  --------+-----------+------------------------------+----------------------------
//  din     | in        | action, phase_value          | din.valid & din.ready
//  dout    | out       | sample (Q1.15), phase        | dout.valid & dout.ready
//  cfg     | in        | index, data (register write) | cfg.valid & cfg.ready
//
// One item is accepted per cycle while din is ready; its result passes through the input
// stage and then the result register, which holds the sample math, before reaching dout.
// While a result waits on dout, the input stage still takes one more item; din
// stalls only when both the input stage and the result are full and dout is not ready.
// Reset clears the phase, the random state and the registers to their defaults;
// cfg is always ready and never stalls.
`default_nettype none
module lfo_waveform_generator #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	lfo_in_if.sink      din,
	lfo_out_if.source   dout,
	lfo_cfg_if.sink     cfg
);
	import lfo_pkg::*;

	localparam int SINE_N = 1 << SINE_TABLE_BITS;

	// Quarter-wave sine entry round(32767*sin(pi/2*k/N)), evaluated at elaboration with
	// a Q30 Taylor series of seven terms.
	function automatic logic [14:0] sine_entry(input int unsigned k, input int tb);
		logic        [63:0] x;
		logic        [63:0] x2;
		logic        [63:0] term;
		logic        [63:0] prod;
		logic signed [63:0] sum;
		x    = (64'd1686629713 * 64'(k)) >> tb;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		for (int i = 1; i <= 6; i++) begin
			prod = (term * x2) >> 30;
			case (i)
				1:       term = prod / 64'd6;
				2:       term = prod / 64'd20;
				3:       term = prod / 64'd42;
				4:       term = prod / 64'd72;
				5:       term = prod / 64'd110;
				default: term = prod / 64'd156;
			endcase
			if (i % 2 == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		sum = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
		if (sum > 64'sd32767) begin
			sum = 64'sd32767;
		end
		return sum[14:0];
	endfunction

	// The table holds entries 0..N-1; the quarter peak at N is a constant of its own.
	localparam logic [14:0] SINE_PEAK = sine_entry(SINE_N, SINE_TABLE_BITS);
	logic [14:0] sine_rom [SINE_N];
	for (genvar k = 0; k < SINE_N; k++) begin : g_sine_rom
		assign sine_rom[k] = sine_entry(k, SINE_TABLE_BITS);
	end

	// Configuration registers and oscillator state.
	wave_t                 waveform_q;
	logic [31:0]           phase_inc_q;
	logic [15:0]           pulse_width_q;
	logic [31:0]           lfsr_q;
	logic [PHASE_BITS-1:0] phase_acc_q;
	logic                  prev_above_q;
	sample_t               rand_cur_q;
	sample_t               rand_prev_q;

	// Input stage.
	logic                  valid_s1;
	action_t               action_s1;
	logic [31:0]           phase_s1;
	sample_t               ra_s1;
	sample_t               rb_s1;

	// Result register.
	logic                  out_valid_q;
	sample_t               sample_q;
	logic [31:0]           phase_q;

	// The input stage moves on when the result register is empty or being emptied.
	logic advance;
	logic accept;
	assign advance   = !out_valid_q || dout.ready;
	assign din.ready = !valid_s1 || advance;
	assign accept    = din.valid && din.ready;
	assign cfg.ready = 1'b1;

	// Conversion between the accumulator width and the 32-bit cycle fraction at the
	// edges. A narrow accumulator drops low bits of the loaded phase and increment.
	logic [PHASE_BITS-1:0] inc_acc;
	logic [PHASE_BITS-1:0] load_acc;
	logic [31:0]           acc_p32;
	logic [31:0]           load_p32;
	if (PHASE_BITS >= 32) begin : g_wide_phase
		assign inc_acc  = PHASE_BITS'(phase_inc_q) << (PHASE_BITS - 32);
		assign load_acc = PHASE_BITS'(din.phase_value) << (PHASE_BITS - 32);
		assign acc_p32  = phase_acc_q[PHASE_BITS-1 -: 32];
		assign load_p32 = load_acc[PHASE_BITS-1 -: 32];
	end else begin : g_narrow_phase
		assign inc_acc  = phase_inc_q[31 -: PHASE_BITS];
		assign load_acc = din.phase_value[31 -: PHASE_BITS];
		assign acc_p32  = 32'(phase_acc_q) << (32 - PHASE_BITS);
		assign load_p32 = 32'(load_acc) << (32 - PHASE_BITS);
	end

	// Random draw: one Galois LFSR step, top half taken as a clamped sample.
	logic        is_random;
	logic        wrap_down;
	logic        above_half;
	logic [31:0] lfsr_next;
	sample_t     rand_draw;
	assign is_random  = (waveform_q == WAVE_RANDOM) || (waveform_q == WAVE_RAND_RAMP);
	assign wrap_down  = !acc_p32[31] && prev_above_q;
	assign above_half = acc_p32[31] && (|acc_p32[30:0]);
	assign lfsr_next  = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? LFSR_MASK : 32'd0);
	assign rand_draw  = (lfsr_next[31:16] == 16'h8000) ? SAMPLE_MIN : sample_t'(lfsr_next[31:16]);

	logic    tick_random;
	logic    draw;
	sample_t rand_cur_next;
	sample_t rand_prev_next;
	assign tick_random    = accept && (din.action == ACT_TICK) && is_random;
	assign draw           = tick_random && wrap_down;
	assign rand_cur_next  = draw ? rand_draw : rand_cur_q;
	assign rand_prev_next = (draw && (waveform_q == WAVE_RAND_RAMP)) ? rand_cur_q : rand_prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q    <= WAVE_TRIANGLE;
			phase_inc_q   <= '0;
			pulse_width_q <= PULSE_WIDTH_RST;
			lfsr_q        <= SEED_RST;
			phase_acc_q   <= '0;
			prev_above_q  <= 1'b0;
			rand_cur_q    <= '0;
			rand_prev_q   <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_WAVEFORM:    waveform_q    <= wave_t'(cfg.data[2:0]);
					CFG_PHASE_INC:   phase_inc_q   <= cfg.data;
					CFG_PULSE_WIDTH: pulse_width_q <= cfg.data[15:0];
					CFG_RANDOM_SEED: lfsr_q        <= (cfg.data == 32'd0) ? SEED_RST : cfg.data;
					default: ;
				endcase
			end
			if (accept) begin
				if (din.action == ACT_LOAD) begin
					phase_acc_q <= load_acc;
				end else begin
					phase_acc_q <= phase_acc_q + inc_acc;
				end
			end
			if (tick_random) begin
				prev_above_q <= above_half;
				rand_cur_q   <= rand_cur_next;
				rand_prev_q  <= rand_prev_next;
			end
			if (draw) begin
				lfsr_q <= lfsr_next;
			end
		end
	end

	// Input stage: the phase at which the sample is taken and the random pair after
	// any draw this item made.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= din.action;
			phase_s1  <= (din.action == ACT_LOAD) ? load_p32 : acc_p32;
			ra_s1     <= rand_prev_next;
			rb_s1     <= rand_cur_next;
		end
	end

	// Sample math on the stored phase.
	logic        [31:0] tri_t;
	logic signed [18:0] tri_v;
	logic signed [18:0] up_v;
	logic signed [18:0] down_v;
	assign tri_t  = phase_s1 + 32'h4000_0000;
	assign tri_v  = tri_t[31] ? (19'sd98304 - $signed({2'b00, tri_t[31:15]}))
	                          : ($signed({2'b00, tri_t[31:15]}) - 19'sd32768);
	assign up_v   = $signed({3'b000, phase_s1[31:16]}) - 19'sd32768;
	assign down_v = 19'sd32768 - $signed({3'b000, phase_s1[31:16]});

	// Sine: the quadrant mirrors the index and sets the sign. A mirrored index of
	// zero lands on the quarter peak.
	logic [SINE_TABLE_BITS-1:0] sine_idx;
	logic [SINE_TABLE_BITS-1:0] sine_mir;
	logic [14:0]                sine_mag;
	sample_t                    sine_v;
	assign sine_idx = phase_s1[29 -: SINE_TABLE_BITS];
	assign sine_mir = SINE_TABLE_BITS'(~sine_idx + 1'b1);
	always_comb begin
		if (!phase_s1[30]) begin
			sine_mag = sine_rom[sine_idx];
		end else if (sine_idx == '0) begin
			sine_mag = SINE_PEAK;
		end else begin
			sine_mag = sine_rom[sine_mir];
		end
		sine_v = phase_s1[31] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
	end

	// Random ramp: prev + (cur - prev) * frac / 65536, rounded toward zero.
	logic signed [16:0] rr_diff;
	logic signed [33:0] rr_prod;
	logic signed [33:0] rr_bias;
	logic signed [17:0] rr_step;
	logic signed [18:0] rr_v;
	assign rr_diff = $signed({rb_s1[15], rb_s1}) - $signed({ra_s1[15], ra_s1});
	assign rr_prod = 34'(rr_diff) * $signed({18'd0, phase_s1[31:16]});
	assign rr_bias = rr_prod + (rr_prod[33] ? 34'sd65535 : 34'sd0);
	assign rr_step = rr_bias[33:16];
	assign rr_v    = 19'(ra_s1) + 19'(rr_step);

	sample_t sample_d;
	always_comb begin
		case (waveform_q)
			WAVE_TRIANGLE:  sample_d = sat16(tri_v);
			WAVE_SINE:      sample_d = sine_v;
			WAVE_RAMP_UP:   sample_d = sat16(up_v);
			WAVE_RAMP_DOWN: sample_d = sat16(down_v);
			WAVE_SQUARE:    sample_d = phase_s1[31] ? SAMPLE_MIN : SAMPLE_MAX;
			WAVE_PULSE:     sample_d = (phase_s1[31:16] < pulse_width_q) ? SAMPLE_MAX
			                                                              : SAMPLE_MIN;
			WAVE_RANDOM:    sample_d = rb_s1;
			default:        sample_d = sat16(rr_v);
		endcase
		if (action_s1 == ACT_LOAD) begin
			sample_d = '0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			sample_q <= sample_d;
			phase_q  <= phase_s1;
		end
	end

	assign dout.valid  = out_valid_q;
	assign dout.sample = sample_q;
	assign dout.phase  = phase_q;

	// An empty input stage must never hold off din.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> din.ready)
		else $error("din stalled with an empty input stage");

	// A load that moves into the result register gives a zero sample.
	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && action_s1 == ACT_LOAD) |=> (dout.valid && dout.sample == 16'sd0))
		else $error("load produced a nonzero sample");

	// Shapes other than the random ones leave the random state untouched.
	a_random_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_random) |=> ($stable(prev_above_q) && $stable(rand_cur_q)))
		else $error("random state changed outside the random shapes");

	// The saturated sample never reaches the most negative code.
	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.sample != -16'sd32768))
		else $error("sample left the symmetric range");

endmodule
`default_nettype wire
